// File: hw/rtl/lmd_pkg.sv
// Shared types, constants and the neighborhood compare for the 3x3 local maximum detector.
// Depends on nothing. Used by lmd_decide, the top level and the bench.
package lmd_pkg;

   localparam int MAX_SIDE   = 64;
   localparam int PIXEL_BITS = 8;
   localparam int SIDE_W     = 7;
   localparam int COORD_W    = $clog2(MAX_SIDE);
   localparam int ADDR_W     = $clog2(MAX_SIDE);
   localparam int NUM_SLOTS  = 4;
   localparam int WIN_CELLS  = 9;

   typedef logic [PIXEL_BITS-1:0] pixel_type;
   typedef logic [WIN_CELLS-1:0][PIXEL_BITS-1:0] window_type;

   // Position of the newest pixel in the window, plus the bounds flags used by the compare
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               row_ge1;
      logic               row_ge2;
      logic               col_ge1;
      logic               col_ge2;
      logic               row_last;
      logic               col_last;
   } pos_type;

   // True when no valid neighbor of cell (wr,wc) is strictly greater.
   // rv/cv flag which window rows/columns lie inside the image.
   function automatic logic cell_max(window_type win, int wr, int wc,
                                     logic [2:0] rv, logic [2:0] cv);
      logic ok;
      ok = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (!(i == wr && j == wc) && i >= wr - 1 && i <= wr + 1 &&
                j >= wc - 1 && j <= wc + 1 && rv[i] && cv[j] &&
                win[i*3+j] > win[wr*3+wc]) begin
               ok = 1'b0;
            end
         end
      end
      return ok;
   endfunction

endpackage

// File: hw/rtl/lmd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module lmd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read while not enabled
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/lmd_decide.sv
// Decides which of the four candidate centers of the 3x3 window are local maxima.
// Depends on lmd_pkg.
module lmd_decide (
   input  lmd_pkg::window_type          win,
   input  lmd_pkg::pos_type             pos,
   output logic [lmd_pkg::NUM_SLOTS-1:0] hit
);
   import lmd_pkg::*;

   logic [2:0] rv;
   logic [2:0] cv;

   // window row 0 is r-2, row 1 is r-1, row 2 is r; same for columns
   assign rv = {1'b1, pos.row_ge1, pos.row_ge2};
   assign cv = {1'b1, pos.col_ge1, pos.col_ge2};

   assign hit[0] = pos.row_ge1  & pos.col_ge1  & cell_max(win, 1, 1, rv, cv);
   assign hit[1] = pos.row_ge1  & pos.col_last & cell_max(win, 1, 2, rv, cv);
   assign hit[2] = pos.row_last & pos.col_ge1  & cell_max(win, 2, 1, rv, cv);
   assign hit[3] = pos.row_last & pos.col_last & cell_max(win, 2, 2, rv, cv);

endmodule

// File: hw/rtl/local_maximum_3x3_detector_top.sv
// Top level of the streaming 3x3 local maximum detector.
// Depends on lmd_pkg, lmd_ram and lmd_decide.
//
// Feed the pixels of a square image of csr_wr_data rows and columns in raster order on the
// req_ channel; the block reports every pixel that no in-image neighbor (diagonals
// included) exceeds, ties counting as maxima, as row, column and value on the rsp_ channel.
// A pixel is reported once its neighbors have arrived, so the pixel at (r,c) releases
// (r-1,c-1), plus (r-1,c) at the end of a row, plus the last row's pixels as they arrive;
// one transfer in gives zero to four transfers out, and rsp_last_of_run marks the final one.
// A new pixel is taken every cycle while the output buffer drains; each input transfer is
// registered in stage 1 alongside its line-store read, then in the output buffer, before
// its first result shows. Results leave one per cycle while rsp_ready is high, from a
// four-slot output buffer that takes the next decided pixel only once it drains, so a pixel
// releasing k > 1 results holds the input until all k have left (end of row and last row).
// The two previous image rows live in one 64-entry RAM, one word per column. A side of 0
// acts as 1 and one above 64 acts as 64. Writing the side restarts the frame; write it
// only while the block is idle. After the final pixel the next one starts a new frame.
module local_maximum_3x3_detector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [5:0]                    rsp_max_row,
   output logic [5:0]                    rsp_max_col,
   output logic [7:0]                    rsp_max_value,
   output logic                          rsp_last_of_run,
   input  logic                          csr_wr_en,
   input  logic [6:0]                    csr_wr_data
);
   import lmd_pkg::*;

   // configuration and raster counters
   logic [SIDE_W-1:0]  side_ff, side_in;
   logic [COORD_W-1:0] row_ff, row_in;
   logic [COORD_W-1:0] col_ff, col_in;

   // stage 1: pixel waiting for its line-store read
   logic               s1_valid_ff, s1_valid_in;
   pixel_type          s1_px_ff, s1_px_in;
   pos_type            s1_pos_ff, s1_pos_in;

   // 3x3 window
   window_type         win_ff, win_in;

   // output buffer: up to four decided pixels of one input
   logic [NUM_SLOTS-1:0]                 b_mask_ff, b_mask_in;
   logic [COORD_W-1:0]                   b_row_ff, b_row_in;
   logic [COORD_W-1:0]                   b_col_ff, b_col_in;
   logic [NUM_SLOTS-1:0][PIXEL_BITS-1:0] b_val_ff, b_val_in;

   logic [SIDE_W-1:0]      side_eff;
   logic [COORD_W-1:0]     last_idx;
   logic                   wrap;
   logic [COORD_W-1:0]     cur_r;
   logic [COORD_W-1:0]     cur_c;
   logic                   in_xfer;
   logic                   out_xfer;
   logic                   s1_adv;
   logic                   buf_free;
   logic [NUM_SLOTS-1:0]   sel;
   logic [NUM_SLOTS-1:0]   hit;
   logic [2*PIXEL_BITS-1:0] rd_data;
   pixel_type              up_px;
   pixel_type              mid_px;
   window_type             win_next;
   pos_type                pos_new;
   logic [PIXEL_BITS-1:0]  val_sel;

   // clamp the side into 1..MAX_SIDE
   always_comb begin
      if (side_ff == '0) begin
         side_eff = SIDE_W'(1);
      end else if (side_ff > SIDE_W'(MAX_SIDE)) begin
         side_eff = SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
   end
   assign last_idx = COORD_W'(side_eff - SIDE_W'(1));

   // handshakes
   assign out_xfer  = rsp_valid & rsp_ready;
   assign sel       = b_mask_ff & (~b_mask_ff + NUM_SLOTS'(1));
   assign buf_free  = ((b_mask_ff & ~(out_xfer ? sel : '0)) == '0);
   assign s1_adv    = s1_valid_ff & buf_free;
   assign req_ready = ~s1_valid_ff | s1_adv;
   assign in_xfer   = req_valid & req_ready;

   // position of the incoming pixel
   assign wrap  = (row_ff > last_idx) || (col_ff > last_idx);
   assign cur_r = wrap ? '0 : row_ff;
   assign cur_c = wrap ? '0 : col_ff;

   always_comb begin
      pos_new.row      = cur_r;
      pos_new.col      = cur_c;
      pos_new.row_ge1  = (cur_r != '0);
      pos_new.row_ge2  = (cur_r > COORD_W'(1));
      pos_new.col_ge1  = (cur_c != '0);
      pos_new.col_ge2  = (cur_c > COORD_W'(1));
      pos_new.row_last = (cur_r == last_idx);
      pos_new.col_last = (cur_c == last_idx);
   end

   // line stores: high half is row r-2, low half is row r-1 of each column
   lmd_ram #(
      .WIDTH (2*PIXEL_BITS),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_pos_ff.col),
      .wr_data ({mid_px, s1_px_ff}),
      .rd_en   (in_xfer),
      .rd_addr (cur_c),
      .rd_data (rd_data)
   );

   assign up_px  = rd_data[2*PIXEL_BITS-1:PIXEL_BITS];
   assign mid_px = rd_data[PIXEL_BITS-1:0];

   // shift the window one column left and insert the new column
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         win_next[i*3+0] = win_ff[i*3+1];
         win_next[i*3+1] = win_ff[i*3+2];
      end
      win_next[2] = up_px;
      win_next[5] = mid_px;
      win_next[8] = s1_px_ff;
   end

   lmd_decide u_decide (
      .win (win_next),
      .pos (s1_pos_ff),
      .hit (hit)
   );

   // next state
   always_comb begin
      side_in     = side_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      s1_valid_in = s1_valid_ff;
      s1_px_in    = s1_px_ff;
      s1_pos_in   = s1_pos_ff;
      win_in      = win_ff;
      b_mask_in   = b_mask_ff;
      b_row_in    = b_row_ff;
      b_col_in    = b_col_ff;
      b_val_in    = b_val_ff;

      // advance the raster counters
      if (in_xfer) begin
         s1_px_in  = req_pixel;
         s1_pos_in = pos_new;
         if (cur_c == last_idx) begin
            col_in = '0;
            row_in = (cur_r == last_idx) ? '0 : cur_r + COORD_W'(1);
         end else begin
            col_in = cur_c + COORD_W'(1);
            row_in = cur_r;
         end
      end

      if (in_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end

      // load the buffer with the decided pixels, or drop the slot just sent
      if (s1_adv) begin
         win_in    = win_next;
         b_mask_in = hit;
         b_row_in  = s1_pos_ff.row;
         b_col_in  = s1_pos_ff.col;
         b_val_in  = {win_next[8], win_next[7], win_next[5], win_next[4]};
      end else if (out_xfer) begin
         b_mask_in = b_mask_ff & ~sel;
      end

      // a side write restarts the frame
      if (csr_wr_en) begin
         side_in = csr_wr_data;
         row_in  = '0;
         col_in  = '0;
         win_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff     <= SIDE_W'(MAX_SIDE);
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
         win_ff      <= '0;
         b_mask_ff   <= '0;
      end else begin
         side_ff     <= side_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
         win_ff      <= win_in;
         b_mask_ff   <= b_mask_in;
      end
      s1_px_ff  <= s1_px_in;
      s1_pos_ff <= s1_pos_in;
      b_row_ff  <= b_row_in;
      b_col_ff  <= b_col_in;
      b_val_ff  <= b_val_in;
   end

   // present the lowest pending slot; slots run (r-1,c-1), (r-1,c), (r,c-1), (r,c)
   always_comb begin
      val_sel = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
         if (sel[k]) begin
            val_sel = val_sel | b_val_ff[k];
         end
      end
   end

   assign rsp_valid       = |b_mask_ff;
   assign rsp_max_row     = (sel[0] | sel[1]) ? b_row_ff - COORD_W'(1) : b_row_ff;
   assign rsp_max_col     = (sel[0] | sel[2]) ? b_col_ff - COORD_W'(1) : b_col_ff;
   assign rsp_max_value   = val_sel;
   assign rsp_last_of_run = ((b_mask_ff & ~sel) == '0);

endmodule

// File: bench/tb_top.sv
// Self-checking bench for local_maximum_3x3_detector_top: random and directed raster frames,
// with results predicted in-bench and compared as they leave the block.
// Depends on lmd_pkg and local_maximum_3x3_detector_top.
module tb_top;
   import lmd_pkg::*;

   // Cycle budget for the whole run, and the quiet time given after the last result before
   // the side register is touched (pixels that release nothing may still be in flight).
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;

   // One reported maximum as it should appear on the rsp_ channel.
   typedef struct packed {
      logic [5:0] row;
      logic [5:0] col;
      pixel_type  value;
      logic       last;
   } peak_type;

   // How the pixel values of a frame are drawn.
   typedef enum int {FILL_FULL, FILL_NARROW, FILL_EXTREMES} fill_kind_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_ready;
   logic [7:0] req_pixel   = '0;
   logic       rsp_valid;
   logic       rsp_ready   = 1'b0;
   logic [5:0] rsp_max_row;
   logic [5:0] rsp_max_col;
   logic [7:0] rsp_max_value;
   logic       rsp_last_of_run;
   logic       csr_wr_en   = 1'b0;
   logic [6:0] csr_wr_data = '0;

   // Bench copy of the block state: side register, two line buffers, window, raster position.
   logic [6:0] side_reg = 7'd64;
   pixel_type  line_buf[2*MAX_SIDE] = '{default: '0};
   pixel_type  win[WIN_CELLS] = '{default: '0};
   int         cur_row = 0;
   int         cur_col = 0;

   peak_type   pending_peaks[$];
   int         mismatch_count = 0;
   int         pixels_sent    = 0;
   int         peaks_checked  = 0;
   int         side_writes    = 0;
   int         cycle_count    = 0;
   int         src_idle_pct   = 0;
   int         snk_stall_pct  = 0;
   int         hold_left      = 0;

   local_maximum_3x3_detector_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_pixel      (req_pixel),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_max_row    (rsp_max_row),
      .rsp_max_col    (rsp_max_col),
      .rsp_max_value  (rsp_max_value),
      .rsp_last_of_run(rsp_last_of_run),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #4 clock = ~clock;

   // Abort a hung run; the limit is far above the slowest legal run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still due", cycle_count,
                  pending_peaks.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // Print one line per mismatch and count every one.
   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0d: %s", cycle_count, what);
      mismatch_count++;
   endtask

   // Clamp the side register the way the block reads it: 0 acts as 1, above 64 as 64.
   function automatic int effective_side();
      if (side_reg == 0) return 1;
      if (side_reg > MAX_SIDE) return MAX_SIDE;
      return int'(side_reg);
   endfunction

   // Window cell (wr,wc) holds pixel (r-2+wr, c-2+wc). A cell is a maximum when no neighbor
   // that lies inside the window and inside the image is strictly greater.
   function automatic logic is_peak(int wr, int wc, int r, int c);
      logic ok;
      int   i, j;
      ok = 1'b1;
      for (int dr = -1; dr <= 1; dr++) begin
         for (int dc = -1; dc <= 1; dc++) begin
            i = wr + dr;
            j = wc + dc;
            if ((dr != 0 || dc != 0) && i >= 0 && i <= 2 && j >= 0 && j <= 2 &&
                r - 2 + i >= 0 && c - 2 + j >= 0 && win[i*3+j] > win[wr*3+wc])
               ok = 1'b0;
         end
      end
      return ok;
   endfunction

   function automatic peak_type make_peak(int wr, int wc, int r, int c);
      peak_type p;
      p.row   = 6'(r - 2 + wr);
      p.col   = 6'(c - 2 + wc);
      p.value = win[wr*3+wc];
      p.last  = 1'b0;
      return p;
   endfunction

   // Advance the bench state by one pixel and queue the maxima it releases, in raster order.
   task automatic predict_peaks(input pixel_type px);
      int        n, r, c, last_idx;
      pixel_type above, middle;
      peak_type  found[$];
      n = effective_side();
      if (cur_row >= n || cur_col >= n) begin
         cur_row = 0;
         cur_col = 0;
      end
      r        = cur_row;
      c        = cur_col;
      last_idx = n - 1;
      above    = line_buf[c];
      middle   = line_buf[MAX_SIDE + c];
      for (int i = 0; i < 3; i++) begin
         win[i*3]   = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = above;
      win[5] = middle;
      win[8] = px;
      line_buf[c]            = middle;
      line_buf[MAX_SIDE + c] = px;

      // Interior pixel up-left, then end-of-row and last-row pixels decided early.
      if (r >= 1 && c >= 1 && is_peak(1, 1, r, c)) found.push_back(make_peak(1, 1, r, c));
      if (r >= 1 && c == last_idx && is_peak(1, 2, r, c))
         found.push_back(make_peak(1, 2, r, c));
      if (r == last_idx && c >= 1 && is_peak(2, 1, r, c))
         found.push_back(make_peak(2, 1, r, c));
      if (r == last_idx && c == last_idx && is_peak(2, 2, r, c))
         found.push_back(make_peak(2, 2, r, c));
      if (found.size() > 0) found[found.size()-1].last = 1'b1;
      foreach (found[k]) pending_peaks.push_back(found[k]);

      if (c == last_idx) begin
         cur_col = 0;
         cur_row = (r == last_idx) ? 0 : r + 1;
      end else begin
         cur_col = c + 1;
      end
   endtask

   // Offer one pixel and hold it until the transfer. Valid drops only when a gap is taken,
   // so back-to-back pixels keep it high without a glitch.
   task automatic send_pixel(input pixel_type px);
      if ($urandom_range(99) < src_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      predict_peaks(px);
      pixels_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   function automatic pixel_type pick_pixel(input fill_kind_type fill);
      case (fill)
         FILL_NARROW:   return pixel_type'($urandom_range(3));
         FILL_EXTREMES: return $urandom_range(1) ? 8'hFF : 8'h00;
         default:       return pixel_type'($urandom_range(255));
      endcase
   endfunction

   task automatic send_frame(input int count, input fill_kind_type fill);
      for (int i = 0; i < count; i++) send_pixel(pick_pixel(fill));
   endtask

   // Drop valid, let every expected result out, then give in-flight pixels time to settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_peaks.size() != 0 || hold_left != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the side register while the block is idle; this restarts the frame.
   task automatic write_side(input logic [6:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      side_reg = value;
      cur_row  = 0;
      cur_col  = 0;
      win      = '{default: '0};
      side_writes++;
   endtask

   // Drive rsp_ready and check each result transfer against the oldest expectation.
   always @(posedge clock) begin : rsp_monitor
      peak_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_peaks.size() == 0) begin
               flag_mismatch($sformatf("unexpected result row %0d col %0d value %0d",
                                       rsp_max_row, rsp_max_col, rsp_max_value));
            end else begin
               want = pending_peaks.pop_front();
               peaks_checked++;
               if (rsp_max_row !== want.row || rsp_max_col !== want.col ||
                   rsp_max_value !== want.value || rsp_last_of_run !== want.last)
                  flag_mismatch($sformatf(
                     "got r%0d c%0d v%0d l%0b, want r%0d c%0d v%0d l%0b",
                     rsp_max_row, rsp_max_col, rsp_max_value, rsp_last_of_run,
                     want.row, want.col, want.value, want.last));
            end
         end
         // Hold off for the requested stretch, otherwise stall at the phase's rate.
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= snk_stall_pct);
         end
      end
   end

   // Side left at its reset value of 64: two full rows and a bit, so every column of the first
   // row of the widest image is decided, then stop mid-frame.
   task automatic test_default_side();
      send_frame(2 * MAX_SIDE + 2, FILL_FULL);
   endtask

   // One-pixel images (side 0 and 1), a flat 2x2 giving four results from one pixel,
   // a single central peak and four corner peaks on a 3x3.
   task automatic test_corner_cases();
      pixel_type one_peak[9] = '{8'd1, 8'd2, 8'd1, 8'd2, 8'd9, 8'd2, 8'd1, 8'd2, 8'd1};
      pixel_type corners[9]  = '{8'hFF, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
                                 8'hFF, 8'h00, 8'hFF};
      write_side(7'd0);
      send_pixel(8'h00);
      send_pixel(8'hFF);
      write_side(7'd1);
      send_pixel(8'h55);
      send_pixel(8'hAA);
      write_side(7'd2);
      repeat (4) send_pixel(8'h80);
      write_side(7'd3);
      foreach (one_peak[i]) send_pixel(one_peak[i]);
      foreach (corners[i]) send_pixel(corners[i]);
   endtask

   // Rewrite the side part way into a frame; the window and position must start over.
   task automatic test_midframe_restart();
      write_side(7'd4);
      send_frame(6, FILL_NARROW);
      write_side(7'd4);
      send_frame(16, FILL_FULL);
   endtask

   // Side above the maximum clamps to 64: the second row starts after 64 pixels.
   task automatic test_oversize_side();
      write_side(7'd127);
      send_frame(MAX_SIDE + 2, FILL_FULL);
   endtask

   // Frames of small sides with random content, now and then a partial tail, under one
   // idling mix; the last frame is cut short so the mix sends exactly the given count.
   task automatic test_random_frames(input int idle_pct, input int stall_pct,
                                     input int items);
      int            sent, pick, n, count;
      logic [6:0]    side;
      fill_kind_type fill;
      sent = 0;
      while (sent < items) begin
         pick = $urandom_range(9);
         side = (pick == 0) ? 7'd0 : (pick == 1) ? 7'd1 : 7'($urandom_range(2, 6));
         write_side(side);
         src_idle_pct  = idle_pct;
         snk_stall_pct = stall_pct;
         n     = effective_side();
         count = $urandom_range(1, 3) * n * n;
         if ($urandom_range(3) == 0) count += $urandom_range(n * n - 1);
         if (count > items - sent) count = items - sent;
         fill  = fill_kind_type'($urandom_range(2));
         send_frame(count, fill);
         sent += count;
      end
   endtask

   // Stop the output for a long stretch while pixels keep coming, so the output buffer
   // fills and the block must refuse input.
   task automatic test_output_backpressure();
      write_side(7'd5);
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      hold_left     = 120;
      send_frame(30, FILL_FULL);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_default_side();
      test_corner_cases();
      test_midframe_restart();
      test_oversize_side();
      test_random_frames(0, 0, 30);
      test_random_frames(86, 0, 30);
      test_random_frames(0, 86, 30);
      test_random_frames(38, 38, 30);
      test_output_backpressure();
      wait_drained();

      if (pending_peaks.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", pending_peaks.size()));
      $display("Covered %0d pixels and %0d reported maxima over %0d side writes (0 to 127),",
               pixels_sent, peaks_checked, side_writes);
      $display("with four idling mixes and one long output stall.");
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
